// ----- design/wpec_pkg.sv -----
// Shared types, sizes, item codes and helpers for the wire plane efficiency counter.
// No dependencies; wpec_rem and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package wpec_pkg;

	localparam int WIRES      = 400;
	localparam int PLANES     = 8;

	localparam int FUNC_W     = 3;
	localparam int PLANE_W    = 3;
	localparam int WIRE_W     = 10;
	localparam int LEN_W      = 12;
	localparam int CNT_W      = 32;
	localparam int EVT_W      = 32;
	localparam int PERIOD_W   = 16;
	localparam int TAG_W      = 8;

	localparam int LIST_AW    = $clog2(WIRES);
	localparam int MAP_AW     = $clog2(WIRES);
	localparam int IDX_W      = $clog2(WIRES + 1);
	localparam int CNT_DEPTH  = PLANES * WIRES;
	localparam int CNT_AW     = $clog2(CNT_DEPTH);
	localparam int DIV_CW     = $clog2(EVT_W);

	localparam logic [LEN_W-1:0]    LEN_MAX    = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(500);

	localparam logic [FUNC_W-1:0] FN_HIT   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PLANE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_EVENT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_READ  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WALK_LIST,
		ST_WALK_W2,
		ST_WALK_W1,
		ST_WALK_CNT,
		ST_WALK_UPD,
		ST_PLANE_END,
		ST_EVT_DIV,
		ST_RD_WAIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [LEN_W-1:0] hits_in_plane;
		logic [CNT_W-1:0] trials;
		logic [CNT_W-1:0] successes;
		logic             report_due;
		logic [EVT_W-1:0] events_seen;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ----- design/wpec_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the hit list, hit map and counter store.
`timescale 1ns / 1ps
`default_nettype none

module wpec_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]   waddr,
	input  logic [W-1:0]                           wdata,
	input  logic                                   re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0]   raddr,
	output logic [W-1:0]                           rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- design/wpec_rem.sv -----
// Bit-serial remainder unit: event count modulo report period, one bit per cycle.
// Depends on wpec_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module wpec_rem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wpec_pkg::EVT_W-1:0]    dividend,
	input  logic [wpec_pkg::PERIOD_W-1:0] divisor,
	output logic                          done,
	output logic [wpec_pkg::PERIOD_W-1:0] rem
);

	import wpec_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [EVT_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   dsr;
	logic [PERIOD_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, dvd_q[EVT_W-1]};
		dsr    = {1'b0, divisor};
		rem_nx = (trial >= dsr) ? PERIOD_W'(trial - dsr) : PERIOD_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CW'(EVT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(EVT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[EVT_W-2:0], 1'b0};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- design/wire_plane_efficiency_counter_unit.sv -----
// Top level of the wire plane efficiency counter: control sequencer, hit list, hit map
// and counter RAMs. Depends on wpec_pkg, wpec_ram and wpec_rem.
//
// Hits may arrive back to back. An end-of-plane beat walks the hit list through the
// single read port of each RAM: a listed wire whose neighbour two up is out of range
// or not hit is passed over, else a counter read-modify-write follows. An end-of-event
// beat waits for the 32-step serial remainder of the event count against the report
// period. A clear beat sweeps all PLANES*WIRES (3200) counter RAM entries before the
// next beat is taken; the same sweep runs after reset, together with a map sweep. Every
// 255th end of plane the hit map tags wrap and a sweep of all WIRES (400) map entries
// follows. Results sit in an output register, so hit beats keep flowing while a result
// waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module wire_plane_efficiency_counter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wpec_pkg::PERIOD_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [wpec_pkg::FUNC_W-1:0]   func,
	input  logic [wpec_pkg::PLANE_W-1:0]  plane,
	input  logic [wpec_pkg::WIRE_W-1:0]   wire_req,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [wpec_pkg::LEN_W-1:0]    hits_in_plane,
	output logic [wpec_pkg::CNT_W-1:0]    trials,
	output logic [wpec_pkg::CNT_W-1:0]    successes,
	output logic                          report_due,
	output logic [wpec_pkg::EVT_W-1:0]    events_seen
);

	import wpec_pkg::*;

	state_t              state_q, state_d;
	logic [PERIOD_W-1:0] period_q;
	logic [LEN_W-1:0]    len_q;
	logic [TAG_W-1:0]    epoch_q;
	logic [EVT_W-1:0]    evt_q;
	logic [CNT_AW-1:0]   sweep_q;
	logic                clr_map_q, clr_cnt_q;
	logic                out_valid_q;

	logic [IDX_W-1:0]    idx_q, n_q;
	logic [PLANE_W-1:0]  plane_q;
	logic [WIRE_W-1:0]   w_q;
	logic                mid_hit_q;
	logic                rd_ok_q;
	logic [CNT_AW-1:0]   k_q;
	res_t                res_q, out_q;

	logic                list_we, list_re;
	logic [LIST_AW-1:0]  list_waddr, list_raddr;
	logic [WIRE_W-1:0]   list_wdata, list_rdata;
	logic                map_we, map_re;
	logic [MAP_AW-1:0]   map_waddr, map_raddr;
	logic [TAG_W-1:0]    map_wdata, map_rdata;
	logic                cnt_we, cnt_re;
	logic [CNT_AW-1:0]   cnt_waddr, cnt_raddr;
	logic [2*CNT_W-1:0]  cnt_wdata, cnt_rdata;

	logic                rem_start, rem_done;
	logic [PERIOD_W-1:0] rem_val;

	logic                acc, plane_ok, wire_ok, len_room, w2_ok, map_hit, last_entry;
	logic                sweep_end, out_free, load;
	logic [WIRE_W:0]     w2, w1;
	logic [IDX_W-1:0]    n_in;
	logic [CNT_AW-1:0]   walk_k, rd_k;
	logic [CNT_W-1:0]    trial_old, succ_old;

	always_comb begin
		acc        = in_valid && (state_q == ST_IDLE);
		plane_ok   = 32'(plane) < PLANES;
		wire_ok    = 32'(wire_req) < WIRES;
		len_room   = 32'(len_q) < WIRES;
		n_in       = len_room ? IDX_W'(len_q) : IDX_W'(WIRES);
		w2         = {1'b0, list_rdata} + (WIRE_W+1)'(2);
		w1         = {1'b0, w_q} + (WIRE_W+1)'(1);
		w2_ok      = 32'(w2) < WIRES;
		map_hit    = map_rdata == epoch_q;
		last_entry = (idx_q + IDX_W'(1)) == n_q;
		sweep_end  = sweep_q == (clr_cnt_q ? CNT_AW'(CNT_DEPTH - 1) : CNT_AW'(WIRES - 1));
		out_free   = !out_valid_q || !out_stall;
		load       = (state_q == ST_RESULT) && out_free;
		walk_k     = CNT_AW'(32'(plane_q) * WIRES + 32'(w1));
		rd_k       = CNT_AW'(32'(plane) * WIRES + 32'(wire_req));
		trial_old  = cnt_rdata[2*CNT_W-1:CNT_W];
		succ_old   = cnt_rdata[CNT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_end) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FN_PLANE: state_d = (plane_ok && n_in != '0) ? ST_WALK_LIST
							: ST_PLANE_END;
						FN_EVENT: state_d = ST_EVT_DIV;
						FN_READ:  state_d = ST_RD_WAIT;
						FN_CLEAR: state_d = ST_INIT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK_LIST: state_d = ST_WALK_W2;
			ST_WALK_W2: begin
				if (w2_ok)           state_d = ST_WALK_W1;
				else if (last_entry) state_d = ST_PLANE_END;
				else                 state_d = ST_WALK_LIST;
			end
			ST_WALK_W1: begin
				if (map_hit)         state_d = ST_WALK_CNT;
				else if (last_entry) state_d = ST_PLANE_END;
				else                 state_d = ST_WALK_LIST;
			end
			ST_WALK_CNT: state_d = ST_WALK_UPD;
			ST_WALK_UPD: state_d = last_entry ? ST_PLANE_END : ST_WALK_LIST;
			ST_PLANE_END: state_d = ST_RESULT;
			ST_EVT_DIV: begin
				if (rem_done) state_d = ST_RESULT;
			end
			ST_RD_WAIT: state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) state_d = clr_map_q ? ST_INIT : ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		in_stall   = state_q != ST_IDLE;
		cfg_ready  = 1'b1;
		rem_start  = acc && (func == FN_EVENT);

		list_we    = acc && (func == FN_HIT) && len_room;
		list_waddr = len_q[LIST_AW-1:0];
		list_wdata = wire_req;
		list_re    = state_q == ST_WALK_LIST;
		list_raddr = idx_q[LIST_AW-1:0];

		map_we     = 1'b0;
		map_waddr  = wire_req[MAP_AW-1:0];
		map_wdata  = epoch_q;
		if (state_q == ST_INIT && clr_map_q && 32'(sweep_q) < WIRES) begin
			map_we    = 1'b1;
			map_waddr = sweep_q[MAP_AW-1:0];
			map_wdata = '0;
		end else if (acc && func == FN_HIT && wire_ok) begin
			map_we = 1'b1;
		end
		map_re     = (state_q == ST_WALK_W2) || (state_q == ST_WALK_W1);
		map_raddr  = (state_q == ST_WALK_W2) ? w2[MAP_AW-1:0] : w1[MAP_AW-1:0];

		cnt_we     = 1'b0;
		cnt_waddr  = k_q;
		cnt_wdata  = {sat_inc(trial_old), mid_hit_q ? sat_inc(succ_old) : succ_old};
		if (state_q == ST_INIT && clr_cnt_q) begin
			cnt_we    = 1'b1;
			cnt_waddr = sweep_q;
			cnt_wdata = '0;
		end else if (state_q == ST_WALK_UPD) begin
			cnt_we = 1'b1;
		end
		cnt_re     = (acc && func == FN_READ && plane_ok && wire_ok)
			|| (state_q == ST_WALK_CNT);
		cnt_raddr  = (state_q == ST_WALK_CNT) ? walk_k : rd_k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			period_q    <= PERIOD_RST;
			len_q       <= '0;
			epoch_q     <= TAG_W'(1);
			evt_q       <= '0;
			sweep_q     <= '0;
			clr_map_q   <= 1'b1;
			clr_cnt_q   <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			case (state_q)
				ST_INIT: begin
					if (sweep_end) begin
						sweep_q   <= '0;
						clr_map_q <= 1'b0;
						clr_cnt_q <= 1'b0;
						if (clr_map_q) epoch_q <= TAG_W'(1);
					end else begin
						sweep_q <= sweep_q + CNT_AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (func)
							FN_HIT: begin
								if (len_q != LEN_MAX) len_q <= len_q + LEN_W'(1);
							end
							FN_CLEAR: begin
								evt_q     <= '0;
								clr_cnt_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_PLANE_END: begin
					len_q <= '0;
					// tags wrap: sweep the map before the next beat
					if (epoch_q == '1) clr_map_q <= 1'b1;
					else               epoch_q   <= epoch_q + TAG_W'(1);
				end
				ST_EVT_DIV: begin
					if (rem_done) evt_q <= sat_inc(evt_q);
				end
				default: ;
			endcase
			if (load)            out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				plane_q <= plane;
				n_q     <= n_in;
				idx_q   <= '0;
				rd_ok_q <= plane_ok && wire_ok;
			end
			ST_WALK_W2: begin
				w_q <= list_rdata;
				if (!w2_ok) idx_q <= idx_q + IDX_W'(1);
			end
			ST_WALK_W1: begin
				if (!map_hit) idx_q <= idx_q + IDX_W'(1);
			end
			ST_WALK_CNT: begin
				mid_hit_q <= map_hit;
				k_q       <= walk_k;
			end
			ST_WALK_UPD: begin
				idx_q <= idx_q + IDX_W'(1);
			end
			ST_PLANE_END: begin
				res_q <= '{hits_in_plane: len_q, trials: '0, successes: '0,
					report_due: 1'b0, events_seen: '0};
			end
			ST_EVT_DIV: begin
				res_q <= '{hits_in_plane: '0, trials: '0, successes: '0,
					report_due: (period_q != '0) && (rem_val == '0),
					events_seen: sat_inc(evt_q)};
			end
			ST_RD_WAIT: begin
				res_q <= '{hits_in_plane: '0,
					trials: rd_ok_q ? trial_old : '0,
					successes: rd_ok_q ? succ_old : '0,
					report_due: 1'b0, events_seen: '0};
			end
			default: ;
		endcase
		if (load) out_q <= res_q;
	end

	assign out_valid     = out_valid_q;
	assign hits_in_plane = out_q.hits_in_plane;
	assign trials        = out_q.trials;
	assign successes     = out_q.successes;
	assign report_due    = out_q.report_due;
	assign events_seen   = out_q.events_seen;

	wpec_ram #(.W(WIRE_W), .D(WIRES)) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.re    (list_re),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	wpec_ram #(.W(TAG_W), .D(WIRES)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	wpec_ram #(.W(2*CNT_W), .D(CNT_DEPTH)) u_cnt (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	wpec_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (evt_q),
		.divisor  (period_q),
		.done     (rem_done),
		.rem      (rem_val)
	);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the wire plane efficiency counter: drives hit, plane, event, read and clear
// beats with random gaps and stalls, predicts every result in a scoreboard and checks it.
// Depends on wpec_pkg and wire_plane_efficiency_counter_unit.
`timescale 1ns / 1ps

module tb_top;
	import wpec_pkg::*;

	localparam int HOLD_CYCLES  = 800;
	localparam int QUIET_CYCLES = 4000;
	localparam int PHASE_ITEMS  = 150;
	localparam int BURST_HITS   = 420;
	localparam int WIRE_TOP     = 2**WIRE_W - 1;
	localparam int PLANE_TOP    = 2**PLANE_W - 1;
	localparam int FUNC_TOP     = 2**FUNC_W - 1;

	class efficiency_scoreboard;
		logic [WIRE_W-1:0]   hit_list [WIRES];
		bit                  hit_map [WIRES];
		int unsigned         list_len;
		logic [CNT_W-1:0]    trial_cnt [CNT_DEPTH];
		logic [CNT_W-1:0]    success_cnt [CNT_DEPTH];
		logic [EVT_W-1:0]    event_cnt;
		logic [PERIOD_W-1:0] period;
		res_t                awaited [$];
		int                  failures;

		function new();
			list_len = 0;
			period   = PERIOD_RST;
			failures = 0;
			foreach (hit_map[i]) hit_map[i] = 1'b0;
			foreach (hit_list[i]) hit_list[i] = '0;
			clear_counters();
		endfunction

		function void clear_counters();
			foreach (trial_cnt[i]) trial_cnt[i] = '0;
			foreach (success_cnt[i]) success_cnt[i] = '0;
			event_cnt = '0;
		endfunction

		function void queue_result(input res_t r);
			awaited.insert(awaited.size(), r);
		endfunction

		function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void walk_plane(input int unsigned pl);
			int unsigned n, w, k;
			n = (list_len < WIRES) ? list_len : WIRES;
			for (int unsigned i = 0; i < n; i++) begin
				w = hit_list[i];
				if (w + 2 < WIRES && hit_map[w + 2] && pl < PLANES) begin
					k = pl * WIRES + w + 1;
					trial_cnt[k] = bump(trial_cnt[k]);
					if (hit_map[w + 1])
						success_cnt[k] = bump(success_cnt[k]);
				end
			end
		endfunction

		function void note_item(input logic [FUNC_W-1:0] f, input logic [PLANE_W-1:0] p,
				input logic [WIRE_W-1:0] w);
			res_t r;
			r = '0;
			case (f)
			FN_HIT: begin
				if (list_len < WIRES)
					hit_list[list_len] = w;
				if (w < WIRES)
					hit_map[w] = 1'b1;
				if (list_len < LEN_MAX)
					list_len++;
			end
			FN_PLANE: begin
				walk_plane(p);
				r.hits_in_plane = LEN_W'(list_len);
				list_len = 0;
				foreach (hit_map[i]) hit_map[i] = 1'b0;
				queue_result(r);
			end
			FN_EVENT: begin
				if (period != 0)
					r.report_due = (event_cnt % period) == 0;
				event_cnt = bump(event_cnt);
				r.events_seen = event_cnt;
				queue_result(r);
			end
			FN_READ: begin
				if (p < PLANES && w < WIRES) begin
					r.trials    = trial_cnt[p * WIRES + w];
					r.successes = success_cnt[p * WIRES + w];
				end
				queue_result(r);
			end
			FN_CLEAR: clear_counters();
			default: ;
			endcase
		endfunction

		function void check_result(input res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: hits %0d trials %0d succ %0d due %0b events %0d",
						got.hits_in_plane, got.trials, got.successes, got.report_due,
						got.events_seen);
				return;
			end
			want = awaited.pop_front();
			if (got.hits_in_plane !== want.hits_in_plane || got.trials !== want.trials ||
					got.successes !== want.successes || got.report_due !== want.report_due ||
					got.events_seen !== want.events_seen) begin
				failures++;
				if (failures <= 10) begin
					$display("mismatch expected: hits %0d trials %0d succ %0d due %0b events %0d",
						want.hits_in_plane, want.trials, want.successes, want.report_due,
						want.events_seen);
					$display("         actual:   hits %0d trials %0d succ %0d due %0b events %0d",
						got.hits_in_plane, got.trials, got.successes, got.report_due,
						got.events_seen);
				end
			end
		endfunction
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [FUNC_W-1:0]   func      = '0;
	logic [PLANE_W-1:0]  plane     = '0;
	logic [WIRE_W-1:0]   wire_req  = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [LEN_W-1:0]    hits_in_plane;
	logic [CNT_W-1:0]    trials;
	logic [CNT_W-1:0]    successes;
	logic                report_due;
	logic [EVT_W-1:0]    events_seen;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_seq       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int items_sent     = 0;

	efficiency_scoreboard sb;

	wire_plane_efficiency_counter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.plane         (plane),
		.wire_req      (wire_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hits_in_plane (hits_in_plane),
		.trials        (trials),
		.successes     (successes),
		.report_due    (report_due),
		.events_seen   (events_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hold the output off for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_seq) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_seen <= hold_seq;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin : beat_monitor
		res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.hits_in_plane = hits_in_plane;
			got.trials        = trials;
			got.successes     = successes;
			got.report_due    = report_due;
			got.events_seen   = events_seen;
			sb.check_result(got);
		end
		if (arst_n && in_valid && !in_stall)
			sb.note_item(func, plane, wire_req);
	end

	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [PLANE_W-1:0] p,
			input logic [WIRE_W-1:0] w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		plane    <= p;
		wire_req <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (f <= FN_CLEAR)
			items_sent++;
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.period = v;
	endtask

	// drop valid, wait for every result, then let clear or map sweeps finish
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic send_plane_sequence();
		int unsigned base, n, pl;
		base = ($urandom_range(0, 99) < 85) ? $urandom_range(0, WIRES - 1)
			: $urandom_range(0, WIRE_TOP);
		n = $urandom_range(1, 20);
		repeat (n) begin
			if ($urandom_range(0, 99) < 5)
				send_item(FUNC_W'($urandom_range(FN_CLEAR + 1, FUNC_TOP)),
					PLANE_W'($urandom), WIRE_W'($urandom));
			else
				send_item(FN_HIT, PLANE_W'($urandom), WIRE_W'(base + $urandom_range(0, 10)));
		end
		pl = $urandom_range(0, PLANE_TOP);
		send_item(FN_PLANE, PLANE_W'(pl), WIRE_W'($urandom));
		repeat ($urandom_range(0, 2))
			send_item(FN_READ, PLANE_W'(pl), WIRE_W'(base + $urandom_range(1, 11)));
		if ($urandom_range(0, 99) < 40)
			send_item(FN_EVENT, PLANE_W'($urandom), WIRE_W'($urandom));
	endtask

	task automatic run_random(input int goal);
		int r, start;
		start = items_sent;
		while (items_sent - start < goal) begin
			r = $urandom_range(0, 99);
			if (r < 65)
				send_plane_sequence();
			else if (r < 78)
				send_item(FN_EVENT, PLANE_W'($urandom), WIRE_W'($urandom));
			else if (r < 90)
				send_item(FN_READ, PLANE_W'($urandom),
					WIRE_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, WIRES - 1)
						: $urandom_range(0, WIRE_TOP)));
			else if (r < 99)
				send_item(FUNC_W'($urandom_range(0, FUNC_TOP)), PLANE_W'($urandom),
					WIRE_W'($urandom));
			else
				send_item(FN_CLEAR, PLANE_W'($urandom), WIRE_W'($urandom));
		end
	endtask

	initial begin : stimulus
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_period(PERIOD_W'(1));
		send_item(FN_READ, 0, 0);
		send_item(FN_EVENT, 0, 0);
		send_item(FN_HIT, PLANE_W'(PLANE_TOP), 10);
		send_item(FN_HIT, 0, 12);
		send_item(FN_HIT, 0, 11);
		send_item(FN_HIT, 0, WIRE_W'(WIRE_TOP));
		send_item(FN_HIT, 0, WIRE_W'(WIRES - 2));
		send_item(FN_HIT, 0, WIRE_W'(WIRES));
		send_item(FN_HIT, 0, 10);
		send_item(FN_PLANE, 5, 0);
		send_item(FN_READ, 5, 11);
		send_item(FN_READ, 5, WIRE_W'(WIRE_TOP));
		send_item(FN_READ, PLANE_W'(PLANE_TOP), WIRE_W'(WIRES - 1));
		send_item(FN_HIT, 0, 0);
		send_item(FN_HIT, 0, 2);
		send_item(FN_PLANE, PLANE_W'(PLANE_TOP), WIRE_W'(WIRE_TOP));
		send_item(FN_READ, PLANE_W'(PLANE_TOP), 1);
		for (int c = FN_CLEAR + 1; c <= FUNC_TOP; c++)
			send_item(FUNC_W'(c), 0, 0);
		send_item(FN_CLEAR, 0, 0);
		send_item(FN_READ, 5, 11);
		send_item(FN_EVENT, 0, 0);
		send_item(FN_PLANE, 0, 0);
		wait_until_drained();

		write_period('1);
		run_random(PHASE_ITEMS / 2);
		hold_seq <= hold_seq + 1;
		repeat (40)
			send_item($urandom_range(0, 1) ? FN_EVENT : FN_READ, PLANE_W'($urandom),
				WIRE_W'($urandom_range(0, WIRES - 1)));
		repeat (BURST_HITS)
			send_item(FN_HIT, PLANE_W'($urandom), WIRE_W'($urandom_range(0, WIRES + 20)));
		send_item(FN_PLANE, PLANE_W'($urandom), WIRE_W'($urandom));
		run_random(PHASE_ITEMS / 2);
		wait_until_drained();

		write_period(PERIOD_W'(3));
		send_idle_pct = 50;
		run_random(PHASE_ITEMS);
		wait_until_drained();

		write_period(PERIOD_W'(0));
		send_idle_pct = 0;
		recv_stall_pct <= 50;
		run_random(PHASE_ITEMS);
		wait_until_drained();

		write_period(PERIOD_W'(7));
		send_idle_pct = 7;
		recv_stall_pct <= 7;
		run_random(PHASE_ITEMS);
		wait_until_drained();

		if (sb.failures == 0 && sb.awaited.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : watchdog
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
